@@ hdl/utf8e_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8e_pkg
// shared types and constants of the utf-8 encoder: field widths, sequence
// lengths and the range limits that pick the length of a sequence
// ----------------------------------------------------------------------------
package utf8e_pkg;

   localparam int CpWidth   = 31;
   localparam int ByteWidth = 8;
   localparam int MaxBytes  = 6;
   localparam int LenWidth  = 3;
   localparam int SeqWidth  = ByteWidth * MaxBytes;

   typedef logic [CpWidth-1:0]   cp_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [LenWidth-1:0]  len_type;
   typedef logic [SeqWidth-1:0]  seq_type;

   // sequence lengths in bytes
   localparam len_type SeqLen1 = 3'd1;
   localparam len_type SeqLen2 = 3'd2;
   localparam len_type SeqLen3 = 3'd3;
   localparam len_type SeqLen4 = 3'd4;
   localparam len_type SeqLen5 = 3'd5;
   localparam len_type SeqLen6 = 3'd6;

   // upper limits (exclusive) of each length class
   localparam cp_type AsciiLimit = 31'h0000_0080;
   localparam cp_type Len2Limit  = 31'h0000_0800;
   localparam cp_type Len3Limit  = 31'h0001_0000;
   localparam cp_type Len4Limit  = 31'h0020_0000;
   localparam cp_type Len5Limit  = 31'h0400_0000;

   // continuation byte tag 10xxxxxx
   localparam logic [1:0] ContTag = 2'b10;

endpackage

@@ hdl/code_point_to_utf8_encoder.sv @@
// ----------------------------------------------------------------------------
// code_point_to_utf8_encoder
// encodes one 31-bit code point per input word into its one to six byte
// utf-8 sequence, sent one byte per output word, lead byte first
// ----------------------------------------------------------------------------
// usage
//   req_* : input channel, one code point per word (valid/ready)
//   rsp_* : output channel, one byte per word; rsp_last_byte marks the final
//           byte of each code point's sequence
//   a code point is taken into a three-stage pipeline: capture, length
//   classification, byte assembly; the assembled sequence then sits in an
//   output shift register that hands out one byte per cycle while rsp_ready is high
//   the lead byte reaches rsp_* through the stage 1, stage 2, stage 3 and
//   output registers, in that order; throughput: one byte per cycle on the
//   output while rsp_ready is high; the byte-wide output register sets
//   this, and a new input word can be taken every cycle while the stages
//   in front of it have room
//   the output register reloads in the same cycle its last byte is taken,
//   so sequences follow each other with no gap
//   reset (synchronous, active high) clears every valid bit; nothing
//   in flight survives it
//   when rsp_ready is low the output holds its byte and the stages fill up
//   behind it, then req_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module code_point_to_utf8_encoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  utf8e_pkg::cp_type     req_code_point,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output utf8e_pkg::byte_type   rsp_out_byte,
   output logic                  rsp_last_byte
);

   // stage 1: captured code point
   logic                 s1_vld_ff, s1_vld_in;
   utf8e_pkg::cp_type    s1_cp_ff;

   // stage 2: code point and its sequence length
   logic                 s2_vld_ff, s2_vld_in;
   utf8e_pkg::cp_type    s2_cp_ff;
   utf8e_pkg::len_type   s2_len_ff, s2_len_in;

   // stage 3: assembled sequence, lead byte in the top byte
   logic                 s3_vld_ff, s3_vld_in;
   utf8e_pkg::seq_type   s3_seq_ff, s3_seq_in;
   utf8e_pkg::len_type   s3_len_ff;

   // output shift register and count of bytes still to send
   logic                 out_vld_ff, out_vld_in;
   utf8e_pkg::seq_type   out_seq_ff, out_seq_in;
   utf8e_pkg::len_type   out_left_ff, out_left_in;

   logic out_last;
   logic out_free;
   logic out_load;
   logic s3_rdy;
   logic s2_rdy;
   logic s1_rdy;

   // ---------------------------------------------------------------------
   // flow control: each stage moves on when the one after it has room
   // ---------------------------------------------------------------------
   assign out_last = (out_left_ff == utf8e_pkg::SeqLen1);
   // output register is free when empty or its last byte goes this cycle
   assign out_free = !out_vld_ff || (rsp_ready && out_last);
   assign out_load = s3_vld_ff && out_free;
   assign s3_rdy   = !s3_vld_ff || out_free;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;

   assign req_ready = s1_rdy;

   assign s1_vld_in = s1_rdy ? req_valid : s1_vld_ff;
   assign s2_vld_in = s2_rdy ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in = s3_rdy ? s2_vld_ff : s3_vld_ff;

   // ---------------------------------------------------------------------
   // stage 2 logic: length class from range compares
   // ---------------------------------------------------------------------
   always_comb begin
      priority if (s1_cp_ff < utf8e_pkg::AsciiLimit) begin
         s2_len_in = utf8e_pkg::SeqLen1;
      end else if (s1_cp_ff < utf8e_pkg::Len2Limit) begin
         s2_len_in = utf8e_pkg::SeqLen2;
      end else if (s1_cp_ff < utf8e_pkg::Len3Limit) begin
         s2_len_in = utf8e_pkg::SeqLen3;
      end else if (s1_cp_ff < utf8e_pkg::Len4Limit) begin
         s2_len_in = utf8e_pkg::SeqLen4;
      end else if (s1_cp_ff < utf8e_pkg::Len5Limit) begin
         s2_len_in = utf8e_pkg::SeqLen5;
      end else begin
         s2_len_in = utf8e_pkg::SeqLen6;
      end
   end

   // ---------------------------------------------------------------------
   // stage 3 logic: lead byte prefix plus six-bit groups, msb group first;
   // the range class guarantees the rest fits the lead byte's free bits
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (s2_len_ff)
         utf8e_pkg::SeqLen1: begin
            s3_seq_in = {1'b0, s2_cp_ff[6:0], 40'h0};
         end
         utf8e_pkg::SeqLen2: begin
            s3_seq_in = {3'b110, s2_cp_ff[10:6],
                         utf8e_pkg::ContTag, s2_cp_ff[5:0], 32'h0};
         end
         utf8e_pkg::SeqLen3: begin
            s3_seq_in = {4'b1110, s2_cp_ff[15:12],
                         utf8e_pkg::ContTag, s2_cp_ff[11:6],
                         utf8e_pkg::ContTag, s2_cp_ff[5:0], 24'h0};
         end
         utf8e_pkg::SeqLen4: begin
            s3_seq_in = {5'b11110, s2_cp_ff[20:18],
                         utf8e_pkg::ContTag, s2_cp_ff[17:12],
                         utf8e_pkg::ContTag, s2_cp_ff[11:6],
                         utf8e_pkg::ContTag, s2_cp_ff[5:0], 16'h0};
         end
         utf8e_pkg::SeqLen5: begin
            s3_seq_in = {6'b111110, s2_cp_ff[25:24],
                         utf8e_pkg::ContTag, s2_cp_ff[23:18],
                         utf8e_pkg::ContTag, s2_cp_ff[17:12],
                         utf8e_pkg::ContTag, s2_cp_ff[11:6],
                         utf8e_pkg::ContTag, s2_cp_ff[5:0], 8'h0};
         end
         utf8e_pkg::SeqLen6: begin
            s3_seq_in = {7'b1111110, s2_cp_ff[30],
                         utf8e_pkg::ContTag, s2_cp_ff[29:24],
                         utf8e_pkg::ContTag, s2_cp_ff[23:18],
                         utf8e_pkg::ContTag, s2_cp_ff[17:12],
                         utf8e_pkg::ContTag, s2_cp_ff[11:6],
                         utf8e_pkg::ContTag, s2_cp_ff[5:0]};
         end
         default: begin
            // lengths outside one to six never reach this stage
            s3_seq_in = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // output register: load a new sequence or shift out the sent byte
   // ---------------------------------------------------------------------
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_seq_in  = out_seq_ff;
      out_left_in = out_left_ff;
      priority if (out_load) begin
         out_vld_in  = 1'b1;
         out_seq_in  = s3_seq_ff;
         out_left_in = s3_len_ff;
      end else if (out_vld_ff && rsp_ready) begin
         out_vld_in  = !out_last;
         out_seq_in  = {out_seq_ff[utf8e_pkg::SeqWidth-utf8e_pkg::ByteWidth-1:0],
                        utf8e_pkg::ByteWidth'(0)};
         out_left_in = out_left_ff - utf8e_pkg::SeqLen1;
      end else begin
         out_vld_in  = out_vld_ff;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_byte  = out_seq_ff[utf8e_pkg::SeqWidth-1 -: utf8e_pkg::ByteWidth];
   assign rsp_last_byte = out_last;

   // ---------------------------------------------------------------------
   // registers: valid bits under reset, payload without
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_cp_ff <= req_code_point;
      end
      if (s2_rdy) begin
         s2_cp_ff  <= s1_cp_ff;
         s2_len_ff <= s2_len_in;
      end
      if (s3_rdy) begin
         s3_seq_ff <= s3_seq_in;
         s3_len_ff <= s2_len_ff;
      end
      out_seq_ff  <= out_seq_in;
      out_left_ff <= out_left_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a word on the output always has one to six bytes left
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_left_ff != 3'd0) && (out_left_ff <= utf8e_pkg::SeqLen6))
      else $error("output byte count out of range");

   // a freshly loaded sequence starts with a lead byte, never 10xxxxxx
   a_lead_first: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_out_byte[7:6] != utf8e_pkg::ContTag)
      else $error("sequence does not start with a lead byte");

   // a byte that is not the last is followed at once by a continuation byte
   a_cont_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte
      |=> rsp_valid && (rsp_out_byte[7:6] == utf8e_pkg::ContTag))
      else $error("continuation byte missing");

   // a stalled stage 3 keeps its sequence
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff && !s3_rdy |=> s3_vld_ff && $stable(s3_seq_ff) && $stable(s3_len_ff))
      else $error("stage 3 lost its word under stall");

   // nothing is presented in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule
